/* hdl/gyi_pkg.sv */
// Shared constants for the gyro yaw integrator: field widths, register indexes and reset values.
package gyi_pkg;

  localparam int RawW   = 16;
  localparam int YawW   = 25;
  localparam int RateW  = 29;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;
  localparam int InDataW = 16;
  localparam int OutDataW = 56;

  localparam logic [YawW-1:0] FULL_TURN = 25'd23592960;
  localparam logic [16:0]     ONE_Q16   = 17'd65536;

  localparam logic [CfgIdxW-1:0] CFG_RATE_SCALE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_COEFF  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_COEFF = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RATE_BIAS    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEAD_BAND    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_POS     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_NEG     = 3'd6;

  localparam logic [15:0]        RST_RATE_SCALE = 16'd1998;
  localparam logic [16:0]        RST_COEFF      = 17'd32768;
  localparam logic signed [23:0] RST_RATE_BIAS  = 24'sd55706;
  localparam logic [22:0]        RST_DEAD_BAND  = 23'd229376;
  localparam logic [23:0]        RST_GAIN_POS   = 24'd1268;
  localparam logic [23:0]        RST_GAIN_NEG   = 24'd13592;

endpackage

/* hdl/gyro_yaw_integrator.sv */
// Yaw integrator: scales a gyro sample, smooths it twice, applies a deadband and integrates.
//
//   Channel  Direction  Handshake           Payload
//   s_*      in         s_tvalid/s_tready   s_tdata[15:0] raw_rate
//   m_*      out        m_tvalid/m_tready   m_tdata[24:0] yaw_angle, m_tdata[53:25] filtered_rate
//   cfg_*    in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// Each item steps through RATE, M1, M2, F1, F2, M3, M4, G1, G2, BAND, M5 and HEAD; the input
// is ready again in the same cycle as the result turns valid. All six products go one after
// another through a single 32x25 signed multiplier with its result registered, each followed
// by the add and saturate steps that consume it.
// The input is taken only in the idle state. When the previous result has not
// been taken, the last step waits until the output register frees up.
// Reset clears the configuration to its defaults and the filter and heading state to zero.
module gyro_yaw_integrator
  import gyi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // [15:0] raw_rate
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [24:0] yaw_angle, [53:25] filtered_rate, [55:54] zero
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RATE = 4'd1;
  localparam logic [3:0] ST_M1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_F1   = 4'd4;
  localparam logic [3:0] ST_F2   = 4'd5;
  localparam logic [3:0] ST_M3   = 4'd6;
  localparam logic [3:0] ST_M4   = 4'd7;
  localparam logic [3:0] ST_G1   = 4'd8;
  localparam logic [3:0] ST_G2   = 4'd9;
  localparam logic [3:0] ST_BAND = 4'd10;
  localparam logic [3:0] ST_M5   = 4'd11;
  localparam logic [3:0] ST_HEAD = 4'd12;

  localparam logic signed [35:0] FIRST_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] FIRST_MIN = 36'shF_8000_0000;
  localparam logic signed [34:0] RATE_MAX  = 35'sh0_0FFF_FFFF;
  localparam logic signed [34:0] RATE_MIN  = 35'sh7_F000_0000;
  localparam logic signed [37:0] TURN_S    = $signed({13'd0, FULL_TURN});

  // configuration
  logic [15:0]        rate_scale;
  logic [16:0]        first_coeff;
  logic [16:0]        second_coeff;
  logic signed [23:0] rate_bias;
  logic [22:0]        dead_band;
  logic [23:0]        gain_pos;
  logic [23:0]        gain_neg;

  // filter and heading state
  logic signed [31:0] last_raw;
  logic signed [31:0] last_first;
  logic [YawW-1:0]    heading;

  // working registers
  logic [3:0]               state;
  logic signed [RawW-1:0]   raw;
  logic signed [31:0]       rate;
  logic signed [31:0]       first;
  logic signed [RateW-1:0]  g;
  logic signed [RateW-1:0]  g_band;
  logic [23:0]              gain;
  logic signed [56:0]       prod;
  logic signed [50:0]       acc;
  logic [YawW-1:0]          yaw_out;
  logic signed [RateW-1:0]  rate_out;

  logic [16:0]        w1;
  logic [16:0]        w2;
  logic signed [31:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [35:0] first_sum;
  logic signed [34:0] g_shift;
  logic signed [29:0] g_wide;
  logic signed [29:0] db_wide;
  logic               in_band;
  logic signed [37:0] head_sum;
  logic signed [37:0] head_wrap;
  logic [YawW-1:0]    heading_next;
  logic               out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {2'b00, rate_out, yaw_out};
  assign out_free  = !m_tvalid || m_tready;

  // A weight above one counts as exactly one.
  assign w1 = (first_coeff > ONE_Q16) ? ONE_Q16 : first_coeff;
  assign w2 = (second_coeff > ONE_Q16) ? ONE_Q16 : second_coeff;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_RATE: begin
        mul_a = {{16{raw[RawW-1]}}, raw};
        mul_b = $signed({9'd0, rate_scale});
      end
      ST_M1: begin
        mul_a = $signed(prod[31:0]);
        mul_b = $signed({8'd0, w1});
      end
      ST_M2: begin
        mul_a = last_raw;
        mul_b = $signed({8'd0, 17'(ONE_Q16 - w1)});
      end
      ST_M3: begin
        mul_a = first;
        mul_b = $signed({8'd0, w2});
      end
      ST_M4: begin
        mul_a = last_first;
        mul_b = $signed({8'd0, 17'(ONE_Q16 - w2)});
      end
      ST_M5: begin
        mul_a = {{3{g_band[RateW-1]}}, g_band};
        mul_b = $signed({1'b0, gain});
      end
      default: begin
      end
    endcase
  end

  // Arithmetic shift of the accumulated sum gives the floor of the Q.16 product.
  assign first_sum = {acc[50], acc[50:16]} + {{12{rate_bias[23]}}, rate_bias};
  assign g_shift   = acc[50:16];

  assign g_wide  = {g[RateW-1], g};
  assign db_wide = $signed({7'd0, dead_band});
  assign in_band = (g_wide > -db_wide) && (g_wide < db_wide);

  // The heading wraps by one turn at most, then saturates to the range from zero to the full turn.
  assign head_sum = $signed({13'd0, heading}) + {prod[52], prod[52:16]};
  always_comb begin
    priority if (head_sum < 0) begin
      head_wrap = head_sum + TURN_S;
    end else if (head_sum > TURN_S) begin
      head_wrap = head_sum - TURN_S;
    end else begin
      head_wrap = head_sum;
    end
    priority if (head_wrap < 0) begin
      heading_next = '0;
    end else if (head_wrap > TURN_S) begin
      heading_next = FULL_TURN;
    end else begin
      heading_next = head_wrap[YawW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_scale   <= RST_RATE_SCALE;
      first_coeff  <= RST_COEFF;
      second_coeff <= RST_COEFF;
      rate_bias    <= RST_RATE_BIAS;
      dead_band    <= RST_DEAD_BAND;
      gain_pos     <= RST_GAIN_POS;
      gain_neg     <= RST_GAIN_NEG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RATE_SCALE:   rate_scale   <= cfg_data[15:0];
        CFG_FIRST_COEFF:  first_coeff  <= cfg_data[16:0];
        CFG_SECOND_COEFF: second_coeff <= cfg_data[16:0];
        CFG_RATE_BIAS:    rate_bias    <= $signed(cfg_data);
        CFG_DEAD_BAND:    dead_band    <= cfg_data[22:0];
        CFG_GAIN_POS:     gain_pos     <= cfg_data;
        CFG_GAIN_NEG:     gain_neg     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The result register loads in the last step and clears once its item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_HEAD && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      last_raw   <= '0;
      last_first <= '0;
      heading    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            raw   <= $signed(s_tdata[RawW-1:0]);
            state <= ST_RATE;
          end
        end
        ST_RATE: begin
          prod  <= mul_a * mul_b;
          state <= ST_M1;
        end
        ST_M1: begin
          rate  <= $signed(prod[31:0]);
          prod  <= mul_a * mul_b;
          state <= ST_M2;
        end
        ST_M2: begin
          acc   <= prod[50:0];
          prod  <= mul_a * mul_b;
          state <= ST_F1;
        end
        ST_F1: begin
          acc   <= acc + prod[50:0];
          state <= ST_F2;
        end
        ST_F2: begin
          priority if (first_sum > FIRST_MAX) begin
            first <= FIRST_MAX[31:0];
          end else if (first_sum < FIRST_MIN) begin
            first <= FIRST_MIN[31:0];
          end else begin
            first <= first_sum[31:0];
          end
          last_raw <= rate;
          state    <= ST_M3;
        end
        ST_M3: begin
          prod  <= mul_a * mul_b;
          state <= ST_M4;
        end
        ST_M4: begin
          acc   <= prod[50:0];
          prod  <= mul_a * mul_b;
          state <= ST_G1;
        end
        ST_G1: begin
          acc   <= acc + prod[50:0];
          state <= ST_G2;
        end
        ST_G2: begin
          priority if (g_shift > RATE_MAX) begin
            g <= RATE_MAX[RateW-1:0];
          end else if (g_shift < RATE_MIN) begin
            g <= RATE_MIN[RateW-1:0];
          end else begin
            g <= g_shift[RateW-1:0];
          end
          last_first <= first;
          state      <= ST_BAND;
        end
        ST_BAND: begin
          // Inside the band the rate reads as zero, so the heading step is zero too.
          g_band <= in_band ? '0 : g;
          priority if (in_band) begin
            gain <= '0;
          end else if (g > 0) begin
            gain <= gain_pos;
          end else if (g < 0) begin
            gain <= gain_neg;
          end else begin
            gain <= '0;
          end
          state <= ST_M5;
        end
        ST_M5: begin
          prod  <= mul_a * mul_b;
          state <= ST_HEAD;
        end
        ST_HEAD: begin
          if (out_free) begin
            heading  <= heading_next;
            yaw_out  <= heading_next;
            rate_out <= g_band;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/gyi_checker.sv */
// Port-level checks for the gyro yaw integrator, bound to the top level.
module gyi_checker
  import gyi_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  // Once an item is taken, the block works on it alone.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // A new result only appears at the end of an item's work.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while the input side was idle");

  // The heading always lies within one full turn.
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[YawW-1:0] <= FULL_TURN))
    else $error("yaw outside 0..360 degrees");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind gyro_yaw_integrator gyi_checker u_gyi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/tb_top.sv */
// Testbench for the gyro yaw integrator: directed and random samples checked against a predictor.
module tb_top
  import gyi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint OneQ16   = longint'(ONE_Q16);
  localparam longint FullTurn = longint'(FULL_TURN);
  localparam longint Int32Max = 64'sd2147483647;
  localparam longint Int32Min = -64'sd2147483648;
  localparam longint RateMax  = 64'sd268435455;
  localparam longint RateMin  = -64'sd268435456;

  typedef struct packed {
    logic [YawW-1:0]         yaw;
    logic signed [RateW-1:0] rate;
  } heading_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;    // [15:0] raw_rate
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;         // [24:0] yaw_angle, [53:25] filtered_rate
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  gyro_yaw_integrator DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Register mirror.
  logic [15:0]        reg_scale;
  logic [16:0]        reg_coeff1;
  logic [16:0]        reg_coeff2;
  logic signed [23:0] reg_bias;
  logic [22:0]        reg_band;
  logic [23:0]        reg_gain_pos;
  logic [23:0]        reg_gain_neg;

  // Filter and heading state.
  longint prev_rate;
  longint prev_first;
  longint heading_q16;

  heading_result_t expected_headings[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  function automatic void reset_mirror();
    reg_scale    = RST_RATE_SCALE;
    reg_coeff1   = RST_COEFF;
    reg_coeff2   = RST_COEFF;
    reg_bias     = RST_RATE_BIAS;
    reg_band     = RST_DEAD_BAND;
    reg_gain_pos = RST_GAIN_POS;
    reg_gain_neg = RST_GAIN_NEG;
    prev_rate    = 0;
    prev_first   = 0;
    heading_q16  = 0;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_RATE_SCALE:   reg_scale    = val[15:0];
      CFG_FIRST_COEFF:  reg_coeff1   = val[16:0];
      CFG_SECOND_COEFF: reg_coeff2   = val[16:0];
      CFG_RATE_BIAS:    reg_bias     = val;
      CFG_DEAD_BAND:    reg_band     = val[22:0];
      CFG_GAIN_POS:     reg_gain_pos = val;
      CFG_GAIN_NEG:     reg_gain_neg = val;
      default: ;
    endcase
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Weights above one count as exactly one; the shift on a signed value floors.
  function automatic longint ema_q16(longint c, longint fresh, longint old);
    longint w;
    w = (c > OneQ16) ? OneQ16 : c;
    return (w * fresh + (OneQ16 - w) * old) >>> 16;
  endfunction

  function automatic heading_result_t integrate_sample(logic signed [15:0] raw);
    longint rate;
    longint first;
    longint g;
    longint k;
    longint band;
    heading_result_t res;
    rate  = longint'(raw) * longint'(reg_scale);
    first = ema_q16(longint'(reg_coeff1), rate, prev_rate) + longint'(reg_bias);
    first = clip(first, Int32Min, Int32Max);
    g     = ema_q16(longint'(reg_coeff2), first, prev_first);
    g     = clip(g, RateMin, RateMax);
    prev_rate  = rate;
    prev_first = first;
    band = longint'(reg_band);
    if (g > -band && g < band) begin
      g = 0;
    end else begin
      k = 0;
      if (g > 0) k = longint'(reg_gain_pos);
      else if (g < 0) k = longint'(reg_gain_neg);
      heading_q16 += (g * k) >>> 16;
    end
    if (heading_q16 < 0) heading_q16 += FullTurn;
    if (heading_q16 > FullTurn) heading_q16 -= FullTurn;
    heading_q16 = clip(heading_q16, 0, FullTurn);
    res.yaw  = heading_q16[YawW-1:0];
    res.rate = g[RateW-1:0];
    return res;
  endfunction

  function automatic bit log_error();
    errors++;
    return errors <= 10;
  endfunction

  task automatic send_raw(input logic signed [15:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    expected_headings.push_back(integrate_sample(v));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic program_regs(input int scale, input int c1, input int c2, input int bias,
                              input int band, input int gpos, input int gneg);
    write_reg(CFG_RATE_SCALE, CfgDataW'(scale));
    write_reg(CFG_FIRST_COEFF, CfgDataW'(c1));
    write_reg(CFG_SECOND_COEFF, CfgDataW'(c2));
    write_reg(CFG_RATE_BIAS, CfgDataW'(bias));
    write_reg(CFG_DEAD_BAND, CfgDataW'(band));
    write_reg(CFG_GAIN_POS, CfgDataW'(gpos));
    write_reg(CFG_GAIN_NEG, CfgDataW'(gneg));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering items, wait for every outstanding result, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_headings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_raw();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(800) - 400);
    endcase
  endfunction

  task automatic randomize_regs();
    int scale;
    int c1;
    int c2;
    int bias;
    int band;
    int gpos;
    int gneg;
    case ($urandom_range(3))
      0:       scale = 65535;
      1:       scale = $urandom_range(65535);
      default: scale = $urandom_range(4000, 500);
    endcase
    c1 = ($urandom_range(4) == 0) ? $urandom_range(131071) : $urandom_range(65536);
    c2 = ($urandom_range(4) == 0) ? $urandom_range(131071) : $urandom_range(65536);
    bias = ($urandom_range(5) == 0) ? $urandom : $urandom_range(13107200) - 6553600;
    case ($urandom_range(4))
      0:       band = 0;
      1:       band = $urandom_range(6553600);
      2:       band = $urandom & 32'h007F_FFFF;
      default: band = $urandom_range(500000);
    endcase
    case ($urandom_range(2))
      0:       gpos = $urandom_range(20000);
      1:       gpos = $urandom & 32'h00FF_FFFF;
      default: gpos = $urandom_range(2000000);
    endcase
    case ($urandom_range(2))
      0:       gneg = $urandom_range(20000);
      1:       gneg = $urandom & 32'h00FF_FFFF;
      default: gneg = $urandom_range(2000000);
    endcase
    program_regs(scale, c1, c2, bias, band, gpos, gneg);
  endtask

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    heading_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_headings.size() == 0) begin
        if (log_error())
          $display("unexpected result: yaw %0d rate %0d", m_tdata[24:0],
                   $signed(m_tdata[53:25]));
      end else begin
        want = expected_headings.pop_front();
        if (m_tdata[24:0] !== want.yaw || m_tdata[53:25] !== want.rate) begin
          if (log_error())
            $display("mismatch: yaw exp %0d got %0d, rate exp %0d got %0d",
                     want.yaw, m_tdata[24:0], want.rate, $signed(m_tdata[53:25]));
        end
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_reset_values();
    send_raw(16'sh7FFF);
    send_raw(16'sh7FFF);
    send_raw(16'sh7FFF);
    send_raw(16'sh8000);
    send_raw(16'sh8000);
    send_raw(16'sh8000);
    send_raw(16'sd0);
    send_raw(16'sd0);
    send_raw(16'sd1);
    send_raw(-16'sd1);
    drain();
  endtask

  // Weights above one, first-stage and rate overflow, large gains and wrapping.
  task automatic test_saturation();
    program_regs(65535, 131071, 98304, 8388607, 0, 16777215, 16777215);
    send_raw(16'sh7FFF);
    send_raw(16'sh7FFF);
    drain();
    program_regs(65535, 131071, 131071, 8388608, 0, 16777215, 16777215);
    send_raw(16'sh8000);
    send_raw(16'sh8000);
    drain();
  endtask

  task automatic test_zero_band();
    program_regs(65535, 65536, 65536, 0, 0, 16777215, 16777215);
    send_raw(16'sd0);
    send_raw(16'sd0);
    drain();
  endtask

  // The widest deadband the register holds, tried with full-scale rates of both signs.
  task automatic test_wide_band();
    program_regs(1998, 32768, 32768, 0, 8388607, 1268, 13592);
    send_raw(16'sh7FFF);
    send_raw(16'sh8000);
    drain();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_left = 400;
    repeat (20) send_raw(pick_raw());
    drain();
  endtask

  task automatic test_extreme_regs();
    program_regs(65535, 65536, 65536, 6553600, 6553600, 16777215, 16777215);
    repeat (40) send_raw(pick_raw());
    drain();
    program_regs(0, 0, 0, -6553600, 0, 0, 0);
    repeat (40) send_raw(pick_raw());
    drain();
  endtask

  task automatic test_random_phase(input int n, input int send_pct, input int recv_pct);
    randomize_regs();
    set_idling(send_pct, recv_pct);
    repeat (n) send_raw(pick_raw());
    drain();
  endtask

  initial begin
    reset_mirror();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_saturation();
    test_zero_band();
    test_wide_band();
    test_backpressure();
    test_extreme_regs();
    test_random_phase(90, 0, 0);
    test_random_phase(90, 87, 0);
    test_random_phase(90, 0, 87);
    test_random_phase(90, 17, 17);
    test_random_phase(90, 0, 0);
    test_random_phase(90, 87, 0);
    test_random_phase(90, 0, 87);
    test_random_phase(90, 17, 17);

    if (expected_headings.size() != 0) errors++;
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
hdl/gyi_pkg.sv
hdl/gyro_yaw_integrator.sv
hdl/gyi_checker.sv
verif/tb_top.sv
